// File: rtl/core/pps_pkg.sv
`timescale 1ns / 1ps

package pps_pkg;

	localparam int COORD_BITS    = 32;
	localparam int NORM_BITS     = 32;
	localparam int FRAC_BITS     = 30;
	localparam int PROD_BITS     = COORD_BITS + NORM_BITS;
	localparam int ACC_BITS      = PROD_BITS + 2;
	localparam int DIST_BITS     = ACC_BITS - FRAC_BITS;
	localparam int MAG_BITS      = DIST_BITS - 1;
	localparam int SUM_BITS      = MAG_BITS + 1;
	localparam int QUO_BITS      = 31;
	localparam int DIV_STAGES    = QUO_BITS;
	localparam int DLO_BITS      = 16;
	localparam int DHI_BITS      = DIST_BITS - DLO_BITS;
	localparam int PLO_BITS      = DLO_BITS + 1 + NORM_BITS;
	localparam int PHI_BITS      = DHI_BITS + NORM_BITS;
	localparam int PACC_BITS     = PHI_BITS + DLO_BITS;
	localparam int PRND_BITS     = PACC_BITS - FRAC_BITS;
	localparam int TQ_BITS       = QUO_BITS + 1;
	localparam int CP_BITS       = COORD_BITS + 1 + TQ_BITS;
	localparam int CRND_BITS     = CP_BITS - FRAC_BITS;
	localparam int SAT_BITS      = PRND_BITS + 2;
	localparam int LATENCY       = DIV_STAGES + 6;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 32;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [NORM_BITS-1:0]  norm_t;
	typedef logic signed [DIST_BITS-1:0]  dist_t;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_NORMAL_X     = 3'd0,
		REG_NORMAL_Y     = 3'd1,
		REG_NORMAL_Z     = 3'd2,
		REG_PLANE_OFFSET = 3'd3
	} cfg_reg_e;

	typedef struct packed {
		coord_t point_a_x;
		coord_t point_a_y;
		coord_t point_a_z;
		coord_t point_b_x;
		coord_t point_b_y;
		coord_t point_b_z;
	} req_t;

	typedef struct packed {
		coord_t dist_a;
		coord_t dist_b;
		logic   a_positive;
		logic   b_positive;
		coord_t proj_x;
		coord_t proj_y;
		coord_t proj_z;
		coord_t cross_x;
		coord_t cross_y;
		coord_t cross_z;
		logic   degenerate;
	} rsp_t;

	typedef struct packed {
		norm_t  nx;
		norm_t  ny;
		norm_t  nz;
		coord_t offset;
	} plane_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

	typedef struct packed {
		point_t a;
		point_t b;
		dist_t  da;
		dist_t  db;
	} front_t;

	typedef struct packed {
		front_t geo;
		logic   degen;
	} side_t;

	function automatic coord_t sat_coord(input logic signed [SAT_BITS-1:0] v);
		if (v > SAT_BITS'(COORD_MAX)) begin
			return COORD_MAX;
		end else if (v < SAT_BITS'(COORD_MIN)) begin
			return COORD_MIN;
		end else begin
			return COORD_BITS'(v);
		end
	endfunction

endpackage

// File: rtl/core/pps_front.sv
`timescale 1ns / 1ps

module pps_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  pps_pkg::req_t   req,
	input  pps_pkg::plane_t plane,
	output logic            out_valid,
	output pps_pkg::front_t out
);

	localparam int ACC_BITS  = pps_pkg::ACC_BITS;
	localparam int PROD_BITS = pps_pkg::PROD_BITS;
	localparam int FRAC_BITS = pps_pkg::FRAC_BITS;
	localparam int DIST_BITS = pps_pkg::DIST_BITS;

	logic                        v_s1, v_s2, v_s3;
	pps_pkg::req_t               req_s1;
	pps_pkg::point_t             a_s2, b_s2;
	logic signed [PROD_BITS-1:0] pa_s2 [3];
	logic signed [PROD_BITS-1:0] pb_s2 [3];
	pps_pkg::front_t             geo_s3;
	logic signed [ACC_BITS-1:0]  acc_a, acc_b;
	logic signed [ACC_BITS-1:0]  half;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		req_s1 <= req;
	end

	always_ff @(posedge clk) begin
		a_s2     <= {req_s1.point_a_x, req_s1.point_a_y, req_s1.point_a_z};
		b_s2     <= {req_s1.point_b_x, req_s1.point_b_y, req_s1.point_b_z};
		pa_s2[0] <= $signed(req_s1.point_a_x) * $signed(plane.nx);
		pa_s2[1] <= $signed(req_s1.point_a_y) * $signed(plane.ny);
		pa_s2[2] <= $signed(req_s1.point_a_z) * $signed(plane.nz);
		pb_s2[0] <= $signed(req_s1.point_b_x) * $signed(plane.nx);
		pb_s2[1] <= $signed(req_s1.point_b_y) * $signed(plane.ny);
		pb_s2[2] <= $signed(req_s1.point_b_z) * $signed(plane.nz);
	end

	assign half  = $signed(ACC_BITS'(1) << (FRAC_BITS - 1));
	assign acc_a = ACC_BITS'(pa_s2[0]) + ACC_BITS'(pa_s2[1]) + ACC_BITS'(pa_s2[2]) + half;
	assign acc_b = ACC_BITS'(pb_s2[0]) + ACC_BITS'(pb_s2[1]) + ACC_BITS'(pb_s2[2]) + half;

	always_ff @(posedge clk) begin
		geo_s3.a  <= a_s2;
		geo_s3.b  <= b_s2;
		geo_s3.da <= $signed(acc_a[FRAC_BITS +: DIST_BITS]) + DIST_BITS'(plane.offset);
		geo_s3.db <= $signed(acc_b[FRAC_BITS +: DIST_BITS]) + DIST_BITS'(plane.offset);
	end

	assign out_valid = v_s3;
	assign out       = geo_s3;

endmodule

// File: rtl/core/pps_div.sv
`timescale 1ns / 1ps

module pps_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  pps_pkg::front_t              geo,
	output logic                         out_valid,
	output logic [pps_pkg::QUO_BITS-1:0] quo,
	output pps_pkg::side_t               side
);

	localparam int DIST_BITS  = pps_pkg::DIST_BITS;
	localparam int MAG_BITS   = pps_pkg::MAG_BITS;
	localparam int SUM_BITS   = pps_pkg::SUM_BITS;
	localparam int QUO_BITS   = pps_pkg::QUO_BITS;
	localparam int DIV_STAGES = pps_pkg::DIV_STAGES;

	logic                 v_s   [DIV_STAGES+1];
	logic [SUM_BITS-1:0]  rem_s [DIV_STAGES+1];
	logic [SUM_BITS-1:0]  sum_s [DIV_STAGES+1];
	logic [QUO_BITS-1:0]  quo_s [DIV_STAGES+1];
	pps_pkg::side_t       side_s[DIV_STAGES+1];

	logic [DIST_BITS-1:0] neg_a, neg_b;
	logic [MAG_BITS-1:0]  mag_a, mag_b;
	logic [SUM_BITS-1:0]  mag_sum;

	assign neg_a   = -geo.da;
	assign neg_b   = -geo.db;
	assign mag_a   = geo.da[DIST_BITS-1] ? neg_a[MAG_BITS-1:0] : geo.da[MAG_BITS-1:0];
	assign mag_b   = geo.db[DIST_BITS-1] ? neg_b[MAG_BITS-1:0] : geo.db[MAG_BITS-1:0];
	assign mag_sum = {1'b0, mag_a} + {1'b0, mag_b};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0]        <= {1'b0, mag_a};
		sum_s[0]        <= mag_sum;
		quo_s[0]        <= '0;
		side_s[0].geo   <= geo;
		side_s[0].degen <= (mag_sum == '0);
	end

	for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_stage
		logic [SUM_BITS:0] twice;
		logic [SUM_BITS:0] diff;
		logic              ge;

		assign twice = {rem_s[j-1], 1'b0};
		assign diff  = twice - {1'b0, sum_s[j-1]};
		assign ge    = (twice >= {1'b0, sum_s[j-1]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else begin
				v_s[j] <= v_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[j]  <= ge ? diff[SUM_BITS-1:0] : twice[SUM_BITS-1:0];
			sum_s[j]  <= sum_s[j-1];
			quo_s[j]  <= {quo_s[j-1][QUO_BITS-2:0], ge};
			side_s[j] <= side_s[j-1];
		end
	end

	assign out_valid = v_s[DIV_STAGES];
	assign quo       = quo_s[DIV_STAGES];
	assign side      = side_s[DIV_STAGES];

endmodule

// File: rtl/core/pps_back.sv
`timescale 1ns / 1ps

module pps_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [pps_pkg::QUO_BITS-1:0] quo,
	input  pps_pkg::side_t               side,
	input  pps_pkg::plane_t              plane,
	output logic                         out_valid,
	output pps_pkg::rsp_t                out
);

	localparam int COORD_BITS = pps_pkg::COORD_BITS;
	localparam int DIST_BITS  = pps_pkg::DIST_BITS;
	localparam int FRAC_BITS  = pps_pkg::FRAC_BITS;
	localparam int DLO_BITS   = pps_pkg::DLO_BITS;
	localparam int DHI_BITS   = pps_pkg::DHI_BITS;
	localparam int PLO_BITS   = pps_pkg::PLO_BITS;
	localparam int PHI_BITS   = pps_pkg::PHI_BITS;
	localparam int PACC_BITS  = pps_pkg::PACC_BITS;
	localparam int PRND_BITS  = pps_pkg::PRND_BITS;
	localparam int TQ_BITS    = pps_pkg::TQ_BITS;
	localparam int CP_BITS    = pps_pkg::CP_BITS;
	localparam int CRND_BITS  = pps_pkg::CRND_BITS;
	localparam int SAT_BITS   = pps_pkg::SAT_BITS;

	logic [TQ_BITS-1:0]           tq;
	logic signed [TQ_BITS-1:0]    t_s;
	pps_pkg::coord_t              a_c [3];
	pps_pkg::coord_t              b_c [3];
	pps_pkg::norm_t               n_c [3];
	logic signed [DLO_BITS:0]     d_lo;
	logic signed [DHI_BITS-1:0]   d_hi;

	logic                         v_s1, v_s2;
	pps_pkg::side_t               side_s1;
	logic signed [CP_BITS-1:0]    cp_s1 [3];
	logic signed [PLO_BITS-1:0]   pl_s1 [3];
	logic signed [PHI_BITS-1:0]   ph_s1 [3];
	pps_pkg::rsp_t                rsp_s2;

	pps_pkg::coord_t              ax [3];
	pps_pkg::coord_t              proj_v [3];
	pps_pkg::coord_t              cross_v [3];

	assign tq   = (TQ_BITS'(quo) + TQ_BITS'(1)) >> 1;
	assign t_s  = $signed(tq);
	assign a_c[0] = side.geo.a.x;
	assign a_c[1] = side.geo.a.y;
	assign a_c[2] = side.geo.a.z;
	assign b_c[0] = side.geo.b.x;
	assign b_c[1] = side.geo.b.y;
	assign b_c[2] = side.geo.b.z;
	assign n_c[0] = plane.nx;
	assign n_c[1] = plane.ny;
	assign n_c[2] = plane.nz;
	assign d_lo = $signed({1'b0, side.geo.da[DLO_BITS-1:0]});
	assign d_hi = $signed(side.geo.da[DIST_BITS-1:DLO_BITS]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		side_s1 <= side;
	end

	for (genvar i = 0; i < 3; i++) begin : g_mul
		logic signed [COORD_BITS:0] delta;

		assign delta = (COORD_BITS + 1)'(b_c[i]) - (COORD_BITS + 1)'(a_c[i]);

		always_ff @(posedge clk) begin
			cp_s1[i] <= delta * t_s;
			pl_s1[i] <= d_lo * n_c[i];
			ph_s1[i] <= d_hi * n_c[i];
		end
	end

	assign ax[0] = side_s1.geo.a.x;
	assign ax[1] = side_s1.geo.a.y;
	assign ax[2] = side_s1.geo.a.z;

	for (genvar i = 0; i < 3; i++) begin : g_fin
		logic signed [PACC_BITS-1:0] pacc;
		logic signed [CP_BITS-1:0]   cacc;
		logic signed [PRND_BITS-1:0] prnd;
		logic signed [CRND_BITS-1:0] crnd;

		assign pacc = (PACC_BITS'(ph_s1[i]) <<< DLO_BITS) + PACC_BITS'(pl_s1[i])
			+ $signed(PACC_BITS'(1) << (FRAC_BITS - 1));
		assign cacc = cp_s1[i] + $signed(CP_BITS'(1) << (FRAC_BITS - 1));
		assign prnd = $signed(pacc[FRAC_BITS +: PRND_BITS]);
		assign crnd = $signed(cacc[FRAC_BITS +: CRND_BITS]);
		assign proj_v[i]  = pps_pkg::sat_coord(SAT_BITS'(ax[i]) - SAT_BITS'(prnd));
		assign cross_v[i] = side_s1.degen ? ax[i]
			: pps_pkg::sat_coord(SAT_BITS'(ax[i]) + SAT_BITS'(crnd));
	end

	always_ff @(posedge clk) begin
		rsp_s2.dist_a     <= pps_pkg::sat_coord(SAT_BITS'(side_s1.geo.da));
		rsp_s2.dist_b     <= pps_pkg::sat_coord(SAT_BITS'(side_s1.geo.db));
		rsp_s2.a_positive <= ~side_s1.geo.da[DIST_BITS-1];
		rsp_s2.b_positive <= ~side_s1.geo.db[DIST_BITS-1];
		rsp_s2.proj_x     <= proj_v[0];
		rsp_s2.proj_y     <= proj_v[1];
		rsp_s2.proj_z     <= proj_v[2];
		rsp_s2.cross_x    <= cross_v[0];
		rsp_s2.cross_y    <= cross_v[1];
		rsp_s2.cross_z    <= cross_v[2];
		rsp_s2.degenerate <= side_s1.degen;
	end

	assign out_valid = v_s2;
	assign out       = rsp_s2;

endmodule

// File: rtl/core/plane_point_segment_unit_core.sv
// A request accepted at one clock edge passes the front registers, the one-bit-per-stage
// divider pipeline and the back registers; its result then shows on rsp, with done high.
// Throughput: one request per cycle; busy stays low and the result is never held.
// Reset: arst_n clears all valid bits and the plane registers to zero at once.
`timescale 1ns / 1ps

module plane_point_segment_unit_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  pps_pkg::req_t                     req,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pps_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [pps_pkg::CFG_DATA_BITS-1:0] cfg_data,
	output logic                              done,
	output pps_pkg::rsp_t                     rsp
);

	pps_pkg::plane_t               plane_q;
	logic                          front_valid;
	pps_pkg::front_t               front_geo;
	logic                          div_valid;
	logic [pps_pkg::QUO_BITS-1:0]  div_quo;
	pps_pkg::side_t                div_side;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (pps_pkg::cfg_reg_e'(cfg_index))
				pps_pkg::REG_NORMAL_X: begin
					plane_q.nx <= pps_pkg::NORM_BITS'(cfg_data);
				end
				pps_pkg::REG_NORMAL_Y: begin
					plane_q.ny <= pps_pkg::NORM_BITS'(cfg_data);
				end
				pps_pkg::REG_NORMAL_Z: begin
					plane_q.nz <= pps_pkg::NORM_BITS'(cfg_data);
				end
				pps_pkg::REG_PLANE_OFFSET: begin
					plane_q.offset <= pps_pkg::COORD_BITS'(cfg_data);
				end
				default: begin
				end
			endcase
		end
	end

	pps_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.req       (req),
		.plane     (plane_q),
		.out_valid (front_valid),
		.out       (front_geo)
	);

	pps_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.geo       (front_geo),
		.out_valid (div_valid),
		.quo       (div_quo),
		.side      (div_side)
	);

	pps_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid),
		.quo       (div_quo),
		.side      (div_side),
		.plane     (plane_q),
		.out_valid (done),
		.out       (rsp)
	);

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(pps_pkg::LATENCY) done)
		else $error("request did not return a result on time");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, pps_pkg::LATENCY))
		else $error("result without a matching request");

	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.degenerate) |-> (rsp.dist_a == '0 && rsp.dist_b == '0
		&& rsp.a_positive && rsp.b_positive))
		else $error("degenerate flag with nonzero distance");
`endif

endmodule
